>>> rtl/core/assert_macros.svh
// Assertion macros shared by the voice session sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk outside reset.
`define VSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge of clk outside reset.
`define VSS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/vss_pkg.sv
// Types and constants of the voice session sequencer.
`timescale 1ns / 1ps

package vss_pkg;

    localparam int TIME_BITS = 32;
    localparam int NOW_BITS = 32;
    localparam int LIMIT_BITS = 24;
    localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [CMP_BITS-1:0] cmp_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_WAKE_DELAY = 3'd0;
    localparam cfg_index_t CFG_MAX_RECORD = 3'd1;
    localparam cfg_index_t CFG_PROC_TIMEOUT = 3'd2;
    localparam cfg_index_t CFG_PLAY_TIMEOUT = 3'd3;

    localparam limit_t WAKE_DELAY_RESET = 24'd300;
    localparam limit_t MAX_RECORD_RESET = 24'd10000;
    localparam limit_t PROC_TIMEOUT_RESET = 24'd15000;
    localparam limit_t PLAY_TIMEOUT_RESET = 24'd60000;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WAKE = 3'd1,
        MODE_REC  = 3'd2,
        MODE_PROC = 3'd3,
        MODE_PLAY = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE      = 3'd0,
        OP_WAKE      = 3'd1,
        OP_START_REC = 3'd2,
        OP_STOP_REC  = 3'd3,
        OP_VAD_SIL   = 3'd4,
        OP_STT_RES   = 3'd5,
        OP_PLAY_TTS  = 3'd6,
        OP_TTS_END   = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_WAKE   = 2'd1,
        CAUSE_RECORD = 2'd2,
        CAUSE_IDLE   = 2'd3
    } cause_t;

endpackage

>>> rtl/core/vss_if.sv
// Valid/ready channel interfaces for update and result transactions.
`timescale 1ns / 1ps

interface vss_upd_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [2:0]  opcode;

    modport source (output valid, output now_ms, output opcode, input ready);
    modport sink (input valid, input now_ms, input opcode, output ready);
endinterface

interface vss_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] session_state;
    logic       start_record;
    logic       stop_record;
    logic       event_taken;
    logic [1:0] timeout_cause;

    modport source (output valid, output session_state, output start_record,
                    output stop_record, output event_taken, output timeout_cause,
                    input ready);
    modport sink (input valid, input session_state, input start_record,
                  input stop_record, input event_taken, input timeout_cause,
                  output ready);
endinterface

>>> rtl/core/voice_session_sequencer.sv
// Top level of the voice session sequencer: session state, timeouts and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one update transaction per clock cycle unless an untaken result stalls it,
// and returns exactly one result transaction for each, in the cycle after it is
// accepted. The event guards, the wrapping elapsed-time subtraction and the timeout
// compare form a single combinational pass from the session state registers and the
// incoming update into the state and result registers. The result register is a single
// stage: an update is accepted whenever that register is empty or its result is being
// taken in the same cycle. Limits must be written through the configuration port
// while idle; the block does not enforce this. Indices of four or more are ignored.

module voice_session_sequencer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  vss_pkg::cfg_index_t     cfg_index,
    input  vss_pkg::limit_t         cfg_wdata,
    vss_upd_if.sink                 upd,
    vss_res_if.source               res
);

    vss_pkg::limit_t wake_delay_reg;
    vss_pkg::limit_t max_record_reg;
    vss_pkg::limit_t proc_timeout_reg;
    vss_pkg::limit_t play_timeout_reg;

    vss_pkg::mode_t  mode_reg;
    vss_pkg::mode_t  mode_next;
    vss_pkg::time_t  entered_reg;
    vss_pkg::time_t  entered_next;

    logic            res_valid_reg;
    vss_pkg::mode_t  res_state_reg;
    logic            res_start_reg;
    logic            res_stop_reg;
    logic            res_taken_reg;
    vss_pkg::cause_t res_cause_reg;

    logic            upd_accept;
    vss_pkg::time_t  now_t;
    vss_pkg::opcode_t op;
    vss_pkg::mode_t  mode_evt;
    vss_pkg::time_t  entered_evt;
    vss_pkg::time_t  elapsed;
    vss_pkg::cmp_t   elapsed_cmp;
    logic            start_next;
    logic            stop_next;
    logic            taken_next;
    vss_pkg::cause_t cause_next;

    assign upd.ready = !res_valid_reg || res.ready;
    assign upd_accept = upd.valid && upd.ready;

    assign now_t = vss_pkg::time_t'(upd.now_ms);
    assign op = vss_pkg::opcode_t'(upd.opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_delay_reg <= vss_pkg::WAKE_DELAY_RESET;
            max_record_reg <= vss_pkg::MAX_RECORD_RESET;
            proc_timeout_reg <= vss_pkg::PROC_TIMEOUT_RESET;
            play_timeout_reg <= vss_pkg::PLAY_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vss_pkg::CFG_WAKE_DELAY:   wake_delay_reg <= cfg_wdata;
                vss_pkg::CFG_MAX_RECORD:   max_record_reg <= cfg_wdata;
                vss_pkg::CFG_PROC_TIMEOUT: proc_timeout_reg <= cfg_wdata;
                vss_pkg::CFG_PLAY_TIMEOUT: play_timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Event phase under the guards of the current state.
    always_comb
    begin
        mode_evt = mode_reg;
        entered_evt = entered_reg;
        start_next = 1'b0;
        stop_next = 1'b0;
        taken_next = 1'b0;
        case (op)
            vss_pkg::OP_WAKE:
            begin
                if (mode_reg == vss_pkg::MODE_IDLE)
                begin
                    mode_evt = vss_pkg::MODE_WAKE;
                    entered_evt = now_t;
                    taken_next = 1'b1;
                end
            end
            vss_pkg::OP_START_REC:
            begin
                if (mode_reg == vss_pkg::MODE_IDLE || mode_reg == vss_pkg::MODE_WAKE)
                begin
                    mode_evt = vss_pkg::MODE_REC;
                    entered_evt = now_t;
                    start_next = 1'b1;
                    taken_next = 1'b1;
                end
            end
            vss_pkg::OP_STOP_REC, vss_pkg::OP_VAD_SIL:
            begin
                if (mode_reg == vss_pkg::MODE_REC)
                begin
                    mode_evt = vss_pkg::MODE_PROC;
                    entered_evt = now_t;
                    stop_next = 1'b1;
                    taken_next = 1'b1;
                end
            end
            vss_pkg::OP_STT_RES:
            begin
                if (mode_reg == vss_pkg::MODE_PROC)
                begin
                    taken_next = 1'b1;
                end
            end
            vss_pkg::OP_PLAY_TTS:
            begin
                if (mode_reg == vss_pkg::MODE_PROC)
                begin
                    mode_evt = vss_pkg::MODE_PLAY;
                    entered_evt = now_t;
                    taken_next = 1'b1;
                end
            end
            vss_pkg::OP_TTS_END:
            begin
                if (mode_reg == vss_pkg::MODE_PLAY)
                begin
                    mode_evt = vss_pkg::MODE_IDLE;
                    entered_evt = now_t;
                    taken_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign elapsed = now_t - entered_evt;
    assign elapsed_cmp = vss_pkg::cmp_t'(elapsed);

    // Timeout phase on the state that the event left.
    always_comb
    begin
        mode_next = mode_evt;
        entered_next = entered_evt;
        cause_next = vss_pkg::CAUSE_NONE;
        case (mode_evt)
            vss_pkg::MODE_WAKE:
            begin
                if (elapsed_cmp > vss_pkg::cmp_t'(wake_delay_reg))
                begin
                    mode_next = vss_pkg::MODE_REC;
                    entered_next = now_t;
                    cause_next = vss_pkg::CAUSE_WAKE;
                end
            end
            vss_pkg::MODE_REC:
            begin
                if (elapsed_cmp > vss_pkg::cmp_t'(max_record_reg))
                begin
                    mode_next = vss_pkg::MODE_PROC;
                    entered_next = now_t;
                    cause_next = vss_pkg::CAUSE_RECORD;
                end
            end
            vss_pkg::MODE_PROC:
            begin
                if (elapsed_cmp > vss_pkg::cmp_t'(proc_timeout_reg))
                begin
                    mode_next = vss_pkg::MODE_IDLE;
                    entered_next = now_t;
                    cause_next = vss_pkg::CAUSE_IDLE;
                end
            end
            vss_pkg::MODE_PLAY:
            begin
                if (elapsed_cmp > vss_pkg::cmp_t'(play_timeout_reg))
                begin
                    mode_next = vss_pkg::MODE_IDLE;
                    entered_next = now_t;
                    cause_next = vss_pkg::CAUSE_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= vss_pkg::MODE_IDLE;
            entered_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd_accept)
            begin
                mode_reg <= mode_next;
                entered_reg <= entered_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_accept)
        begin
            res_state_reg <= mode_next;
            res_start_reg <= start_next || (cause_next == vss_pkg::CAUSE_WAKE);
            res_stop_reg <= stop_next || (cause_next == vss_pkg::CAUSE_RECORD);
            res_taken_reg <= taken_next;
            res_cause_reg <= cause_next;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.session_state = res_state_reg;
    assign res.start_record = res_start_reg;
    assign res.stop_record = res_stop_reg;
    assign res.event_taken = res_taken_reg;
    assign res.timeout_cause = res_cause_reg;

    `VSS_ASSERT(a_state_matches_result, upd_accept |=> (res.session_state == mode_reg), "result state differs from session state")
    `VSS_NEVER(a_start_and_stop, res_valid_reg && res_start_reg && res_stop_reg, "start and stop record in one result")
    `VSS_ASSERT(a_wake_timeout_starts, (res_valid_reg && res_cause_reg == vss_pkg::CAUSE_WAKE) |-> (res_start_reg && res_state_reg == vss_pkg::MODE_REC), "wake timeout without recording start")
    `VSS_ASSERT(a_stop_enters_proc, (res_valid_reg && res_stop_reg) |-> (res_state_reg == vss_pkg::MODE_PROC), "recording stop outside processing")

endmodule
